// ===== sv/brf_pkg.sv =====
package brf_pkg;

   // defaults for the top level parameters
   localparam int DEPTH_DEFAULT      = 1024;
   localparam int WORD_BYTES_DEFAULT = 8;

   // payload widths
   localparam int OP_W   = 3;
   localparam int DATA_W = 64;
   localparam int AMT_W  = 11;
   localparam int OFS_W  = 10;
   localparam int STS_W  = 2;
   localparam int CAP_W  = 11;
   localparam int CAP_MAX = (2 ** CAP_W) - 1;

   // widths of the byte steering fields, sized for at most eight lanes
   localparam int ROT_W = 3;
   localparam int CNT_W = 4;

   typedef enum logic [OP_W-1:0] {
      OP_WRITE = 3'd0,
      OP_READ  = 3'd1,
      OP_PEEK  = 3'd2,
      OP_DRAIN = 3'd3,
      OP_CLEAR = 3'd4
   } op_type;

   typedef enum logic [STS_W-1:0] {
      ST_OK       = 2'd0,
      ST_NO_SPACE = 2'd1,
      ST_NO_DATA  = 2'd2,
      ST_BAD_LEN  = 2'd3
   } status_type;

   // what the access stage hands to the result stage
   typedef struct packed {
      status_type         status;
      logic [CAP_W-1:0]   fill_level;
      logic [CAP_W-1:0]   free_space;
      logic [CNT_W-1:0]   byte_count;
      logic [ROT_W-1:0]   rot;
   } stage_type;

   // lane select bits: lanes are a power of two, at least two
   function automatic int bank_bits(input int word_bytes);
      return (word_bytes > 4) ? 3 : ((word_bytes > 2) ? 2 : 1);
   endfunction

   // ring position bits: a power of two ring covering the depth
   function automatic int addr_bits(input int depth, input int word_bytes);
      return ($clog2(depth) > bank_bits(word_bytes)) ?
             $clog2(depth) : bank_bits(word_bytes) + 1;
   endfunction

endpackage

// ===== sv/brf_req_if.sv =====
interface brf_req_if import brf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [DATA_W-1:0] data_in;
   logic [AMT_W-1:0]  amount;
   logic [OFS_W-1:0]  offset;

   modport source (output valid, output operation, output data_in, output amount,
                   output offset, input ready);
   modport sink   (input valid, input operation, input data_in, input amount,
                   input offset, output ready);
endinterface

// ===== sv/brf_rsp_if.sv =====
interface brf_rsp_if import brf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_out;
   logic [STS_W-1:0]  status;
   logic [CAP_W-1:0]  fill_level;
   logic [CAP_W-1:0]  free_space;

   modport source (output valid, output data_out, output status, output fill_level,
                   output free_space, input ready);
   modport sink   (input valid, input data_out, input status, input fill_level,
                   input free_space, output ready);
endinterface

// ===== sv/brf_bank.sv =====
module brf_bank #(
   parameter int ROW_W = 7
) (
   input  logic             clock,
   input  logic             we,
   input  logic             re,
   input  logic [ROW_W-1:0] addr,
   input  logic [7:0]       wdata,
   output logic [7:0]       rdata
);

   logic [7:0] mem [2 ** ROW_W];
   logic [7:0] rdata_ff;

   // one byte lane of the ring, registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/brf_ctrl.sv =====
module brf_ctrl import brf_pkg::*; #(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int WORD_BYTES = WORD_BYTES_DEFAULT,
   parameter int BSEL       = bank_bits(WORD_BYTES),
   parameter int AW         = addr_bits(DEPTH, WORD_BYTES)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            adv,
   input  logic                            req_accept,
   input  logic [OP_W-1:0]                 operation,
   input  logic [DATA_W-1:0]               data_in,
   input  logic [AMT_W-1:0]                amount,
   input  logic [OFS_W-1:0]                offset,
   input  logic                            csr_we,
   input  logic [CAP_W-1:0]                csr_wdata,
   output logic [(2**BSEL)-1:0]            bank_we,
   output logic [(2**BSEL)-1:0][AW-BSEL-1:0] bank_addr,
   output logic [(2**BSEL)-1:0][7:0]       bank_wdata,
   output logic                            s1_valid,
   output stage_type                       s1
);

   localparam int BANKS   = 2 ** BSEL;
   localparam int CAP_TOP = (DEPTH > CAP_MAX) ? CAP_MAX : DEPTH;

   logic [CAP_W-1:0] cap_top;
   logic [AW-1:0]    head_ff, head_in;
   logic [AW-1:0]    tail_ff, tail_in;
   logic [CAP_W-1:0] count_ff, count_in;
   logic [CAP_W-1:0] cap_ff, cap_in;
   logic             s1_valid_ff;
   stage_type        s1_ff, s1_in;

   logic             bad_len;
   logic [CAP_W-1:0] room;
   logic [AMT_W:0]   peek_end;
   logic [AW-1:0]    start;
   logic             write_go;
   logic             read_go;
   status_type       status_v;

   logic [BANKS-1:0][BSEL-1:0] lane_idx;
   logic [BANKS-1:0][AW-1:0]   lane_pos;

   assign cap_top = CAP_W'(CAP_TOP);

   // length and fill checks
   assign bad_len  = (amount == '0) || (amount > AMT_W'(WORD_BYTES));
   assign room     = cap_ff - count_ff;
   assign peek_end = (AMT_W+1)'(offset) + (AMT_W+1)'(amount);

   // operation decode and pointer update
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      cap_in   = cap_ff;
      status_v = ST_OK;
      write_go = 1'b0;
      read_go  = 1'b0;
      start    = head_ff;
      case (operation)
         OP_WRITE: begin
            start = tail_ff;
            if (bad_len) begin
               status_v = ST_BAD_LEN;
            end else if (amount > room) begin
               status_v = ST_NO_SPACE;
            end else begin
               write_go = 1'b1;
               tail_in  = tail_ff + AW'(amount);
               count_in = count_ff + amount;
            end
         end
         OP_READ: begin
            if (bad_len) begin
               status_v = ST_BAD_LEN;
            end else if (amount > count_ff) begin
               status_v = ST_NO_DATA;
            end else begin
               read_go  = 1'b1;
               head_in  = head_ff + AW'(amount);
               count_in = count_ff - amount;
            end
         end
         OP_PEEK: begin
            start = head_ff + AW'(offset);
            if (bad_len) begin
               status_v = ST_BAD_LEN;
            end else if (peek_end > (AMT_W+1)'(count_ff)) begin
               status_v = ST_NO_DATA;
            end else begin
               read_go = 1'b1;
            end
         end
         OP_DRAIN: begin
            if (amount > count_ff) begin
               status_v = ST_NO_DATA;
            end else begin
               head_in  = head_ff + AW'(amount);
               count_in = count_ff - amount;
            end
         end
         OP_CLEAR: begin
            head_in  = '0;
            tail_in  = '0;
            count_in = '0;
         end
         default: begin
         end
      endcase
      // capacity write clamps and empties the ring
      if (csr_we) begin
         if (csr_wdata == '0) begin
            cap_in = CAP_W'(1);
         end else if (csr_wdata > cap_top) begin
            cap_in = cap_top;
         end else begin
            cap_in = csr_wdata;
         end
         head_in  = '0;
         tail_in  = '0;
         count_in = '0;
      end
   end

   // per lane byte slot and row
   always_comb begin
      for (int b = 0; b < BANKS; b++) begin
         lane_idx[b]   = BSEL'(b) - start[BSEL-1:0];
         lane_pos[b]   = start + AW'(lane_idx[b]);
         bank_addr[b]  = lane_pos[b][AW-1:BSEL];
         bank_wdata[b] = data_in[{lane_idx[b], 3'b000} +: 8];
         bank_we[b]    = req_accept && write_go && (AMT_W'(lane_idx[b]) < amount);
      end
   end

   // result fields for the next stage
   always_comb begin
      s1_in.status     = status_v;
      s1_in.fill_level = count_in;
      s1_in.free_space = cap_in - count_in;
      s1_in.byte_count = read_go ? CNT_W'(amount) : '0;
      s1_in.rot        = ROT_W'(start[BSEL-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
         cap_ff      <= cap_top;
         s1_valid_ff <= 1'b0;
      end else begin
         if (req_accept || csr_we) begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            count_ff <= count_in;
            cap_ff   <= cap_in;
         end
         if (adv) begin
            s1_valid_ff <= req_accept;
            s1_ff       <= s1_in;
         end
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1       = s1_ff;

endmodule

// ===== sv/brf_out.sv =====
module brf_out import brf_pkg::*; #(
   parameter int WORD_BYTES = WORD_BYTES_DEFAULT,
   parameter int BSEL       = bank_bits(WORD_BYTES)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     s1_valid,
   input  stage_type                s1,
   input  logic [(2**BSEL)-1:0][7:0] bank_q,
   brf_rsp_if.source                rsp_if
);

   logic              rsp_valid_ff;
   logic [DATA_W-1:0] data_ff, data_in;
   logic [STS_W-1:0]  status_ff;
   logic [CAP_W-1:0]  fill_ff;
   logic [CAP_W-1:0]  free_ff;

   // rotate lanes back into fifo order, zero past the byte count
   always_comb begin
      data_in = '0;
      for (int i = 0; i < WORD_BYTES; i++) begin
         if (CNT_W'(i) < s1.byte_count) begin
            data_in[8*i +: 8] = bank_q[s1.rot[BSEL-1:0] + BSEL'(i)];
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s1_valid;
         data_ff      <= data_in;
         status_ff    <= s1.status;
         fill_ff      <= s1.fill_level;
         free_ff      <= s1.free_space;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.data_out   = data_ff;
   assign rsp_if.status     = status_ff;
   assign rsp_if.fill_level = fill_ff;
   assign rsp_if.free_space = free_ff;

endmodule

// ===== sv/byte_ring_fifo_with_peek_top.sv =====
// channel | dir | transfer when         | payload
// req_if  | in  | valid && ready        | operation, data_in, amount, offset
// rsp_if  | out | valid && ready        | data_out, status, fill_level, free_space
// csr     | in  | csr_we                | csr_wdata (capacity)
//
// one item per cycle while the result side is not stalled; the byte lane memories
// are read at the transfer edge, and the lanes are then rotated into the result
// register
// reset is synchronous and active high: ring empty, capacity set to DEPTH, clamped to CAP_MAX
// a capacity write empties the ring
// a stalled result holds the whole two stage pipe; req_if.ready is low then
module byte_ring_fifo_with_peek_top import brf_pkg::*; #(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int WORD_BYTES = WORD_BYTES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   brf_req_if.sink          req_if,
   brf_rsp_if.source        rsp_if,
   input  logic             csr_we,
   input  logic [CAP_W-1:0] csr_wdata
);

   localparam int BSEL  = bank_bits(WORD_BYTES);
   localparam int BANKS = 2 ** BSEL;
   localparam int AW    = addr_bits(DEPTH, WORD_BYTES);

   logic                         adv;
   logic                         req_accept;
   logic [BANKS-1:0]             bank_we;
   logic [BANKS-1:0][AW-BSEL-1:0] bank_addr;
   logic [BANKS-1:0][7:0]        bank_wdata;
   logic [BANKS-1:0][7:0]        bank_q;
   logic                         s1_valid;
   stage_type                    s1;

   // pipe advances unless the result register is stalled
   assign adv          = !rsp_if.valid || rsp_if.ready;
   assign req_if.ready = adv;
   assign req_accept   = req_if.valid && adv;

   brf_ctrl #(
      .DEPTH      (DEPTH),
      .WORD_BYTES (WORD_BYTES),
      .BSEL       (BSEL),
      .AW         (AW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .req_accept (req_accept),
      .operation  (req_if.operation),
      .data_in    (req_if.data_in),
      .amount     (req_if.amount),
      .offset     (req_if.offset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .bank_we    (bank_we),
      .bank_addr  (bank_addr),
      .bank_wdata (bank_wdata),
      .s1_valid   (s1_valid),
      .s1         (s1)
   );

   // byte lanes of the ring
   for (genvar b = 0; b < BANKS; b++) begin : g_bank
      brf_bank #(
         .ROW_W (AW - BSEL)
      ) u_bank (
         .clock (clock),
         .we    (bank_we[b]),
         .re    (adv),
         .addr  (bank_addr[b]),
         .wdata (bank_wdata[b]),
         .rdata (bank_q[b])
      );
   end

   brf_out #(
      .WORD_BYTES (WORD_BYTES),
      .BSEL       (BSEL)
   ) u_out (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .s1_valid (s1_valid),
      .s1       (s1),
      .bank_q   (bank_q),
      .rsp_if   (rsp_if)
   );

`ifndef SYNTHESIS
   a_accept_to_stage: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid)
      else $error("transfer did not reach the access stage");

   a_stage_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (s1_valid && adv) |=> rsp_if.valid)
      else $error("access stage item did not reach the result register");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && (rsp_if.status != ST_OK)) |-> (rsp_if.data_out == '0))
      else $error("refused operation returned data");
`endif

endmodule

// ===== tb/brf_ring_checker.sv =====
// watches both channels and the capacity port, predicts every result of the
// ring and compares it with what the block returns
module brf_ring_checker import brf_pkg::*; #(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int WORD_BYTES = WORD_BYTES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   brf_req_if               req_bus,
   brf_rsp_if               rsp_bus,
   input  logic             csr_we,
   input  logic [CAP_W-1:0] csr_wdata,
   output int               fail_count,
   output int               pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [DATA_W-1:0] data_out;
      status_type        status;
      logic [CAP_W-1:0]  fill_level;
      logic [CAP_W-1:0]  free_space;
   } ring_result_type;

   // predicted ring contents and pointers
   logic [7:0]  ring_bytes [DEPTH];
   int unsigned head_pos;
   int unsigned tail_pos;
   int unsigned fill_cnt;
   int unsigned ring_cap;

   ring_result_type awaited_results [$];
   int              mismatch_total = 0;

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   function automatic int unsigned ring_step(input int unsigned pos, input int unsigned by);
      int unsigned p;
      p = pos + by;
      while (p >= ring_cap) p -= ring_cap;
      return p;
   endfunction

   function automatic logic [DATA_W-1:0] collect_bytes(input int unsigned start,
                                                       input int unsigned count);
      logic [DATA_W-1:0] word;
      int unsigned       pos;
      word = '0;
      pos  = start;
      for (int unsigned i = 0; i < count; i++) begin
         word[8*i +: 8] = ring_bytes[pos];
         pos = ring_step(pos, 1);
      end
      return word;
   endfunction

   function automatic void empty_ring();
      head_pos = 0;
      tail_pos = 0;
      fill_cnt = 0;
   endfunction

   // a capacity write clamps to 1..DEPTH and empties the ring
   function automatic void load_capacity(input logic [CAP_W-1:0] value);
      int unsigned c;
      c = value;
      if (c == 0) c = 1;
      if (c > DEPTH) c = DEPTH;
      ring_cap = c;
      empty_ring();
   endfunction

   // one operation on the predicted ring, returns the result it causes
   function automatic ring_result_type ring_operation(input logic [OP_W-1:0]   code,
                                                      input logic [DATA_W-1:0] data,
                                                      input logic [AMT_W-1:0]  amt,
                                                      input logic [OFS_W-1:0]  ofs);
      ring_result_type r;
      int unsigned     count;
      int unsigned     skip;
      bit              sized;
      r.data_out = '0;
      r.status   = ST_OK;
      count      = amt;
      skip       = ofs;
      sized      = (code == OP_WRITE) || (code == OP_READ) || (code == OP_PEEK);
      // length check comes before anything else
      if (sized && (count == 0 || count > WORD_BYTES)) begin
         r.status = ST_BAD_LEN;
      end else begin
         case (code)
            OP_WRITE: begin
               if (count > ring_cap - fill_cnt) begin
                  r.status = ST_NO_SPACE;
               end else begin
                  for (int unsigned i = 0; i < count; i++) begin
                     ring_bytes[tail_pos] = data[8*i +: 8];
                     tail_pos = ring_step(tail_pos, 1);
                  end
                  fill_cnt += count;
               end
            end
            OP_READ: begin
               if (count > fill_cnt) begin
                  r.status = ST_NO_DATA;
               end else begin
                  r.data_out = collect_bytes(head_pos, count);
                  head_pos   = ring_step(head_pos, count);
                  fill_cnt  -= count;
               end
            end
            OP_PEEK: begin
               if (skip + count > fill_cnt) begin
                  r.status = ST_NO_DATA;
               end else begin
                  r.data_out = collect_bytes(ring_step(head_pos, skip), count);
               end
            end
            OP_DRAIN: begin
               if (count > fill_cnt) begin
                  r.status = ST_NO_DATA;
               end else begin
                  head_pos  = ring_step(head_pos, count);
                  fill_cnt -= count;
               end
            end
            OP_CLEAR: begin
               empty_ring();
            end
            default: ;
         endcase
      end
      r.fill_level = CAP_W'(fill_cnt);
      r.free_space = CAP_W'(ring_cap - fill_cnt);
      return r;
   endfunction

   function automatic void log_mismatch(input string what, input ring_result_type want,
                                        input ring_result_type got);
      mismatch_total++;
      if (mismatch_total <= 10) begin
         $display("%0t: %s: expected data %h status %s fill %0d free %0d",
                  $realtime, what, want.data_out, want.status.name(), want.fill_level,
                  want.free_space);
         $display("%0t: %s: got data %h status %s fill %0d free %0d",
                  $realtime, what, got.data_out, got.status.name(), got.fill_level,
                  got.free_space);
      end
   endfunction

   // sample every transfer at the rising edge
   always @(posedge clock) begin
      ring_result_type got;
      ring_result_type want;
      if (reset) begin
         ring_cap = DEPTH;
         empty_ring();
         awaited_results.delete();
      end else begin
         if (csr_we) load_capacity(csr_wdata);

         // result transfer: compare with the oldest prediction
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.data_out   = rsp_bus.data_out;
            got.status     = status_type'(rsp_bus.status);
            got.fill_level = rsp_bus.fill_level;
            got.free_space = rsp_bus.free_space;
            if (awaited_results.size() == 0) begin
               log_mismatch("result with nothing pending", got, got);
            end else begin
               want = awaited_results.pop_front();
               if (got.data_out !== want.data_out || got.status !== want.status ||
                   got.fill_level !== want.fill_level ||
                   got.free_space !== want.free_space)
                  log_mismatch("result mismatch", want, got);
            end
         end

         // request transfer: predict its result
         if (req_bus.valid && req_bus.ready)
            awaited_results.push_back(ring_operation(req_bus.operation, req_bus.data_in,
                                                     req_bus.amount, req_bus.offset));
      end
      pending_count <= awaited_results.size();
      fail_count    <= mismatch_total;
   end

endmodule

// ===== tb/byte_ring_fifo_with_peek_top_tb.sv =====
module byte_ring_fifo_with_peek_top_tb import brf_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH       = DEPTH_DEFAULT;
   localparam int WORD_BYTES  = WORD_BYTES_DEFAULT;
   localparam int AMT_MAX     = (1 << AMT_W) - 1;
   localparam int OFS_MAX     = (1 << OFS_W) - 1;
   localparam int HOLD_CYCLES = 200;
   localparam logic [OP_W-1:0] OP_CODE_TOP   = '1;
   localparam logic [OP_W-1:0] OP_CODE_SPARE = OP_W'(OP_CLEAR + 1);

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_we = 1'b0;
   logic [CAP_W-1:0] csr_wdata = '0;

   int fail_count;
   int pending_count;

   // pacing controls for the two sides
   bit src_gaps_on   = 1'b1;
   bit snk_stalls_on = 1'b1;
   int holds_asked   = 0;
   int holds_done    = 0;
   int cur_cap       = DEPTH;

   int phase_caps [10] = '{2047, 8, 13, 1024, 2, 100, 1, 1000, 37, 600};

   brf_req_if req_bus ();
   brf_rsp_if rsp_bus ();

   byte_ring_fifo_with_peek_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   brf_ring_checker ring_check (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #10 clock = ~clock;

   // one request transfer, with an optional gap in front
   task automatic send_item(input logic [OP_W-1:0] code, input logic [DATA_W-1:0] data,
                            input int amt, input int ofs);
      int gap;
      gap = src_gaps_on ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.operation <= code;
      req_bus.data_in   <= data;
      req_bus.amount    <= amt[AMT_W-1:0];
      req_bus.offset    <= ofs[OFS_W-1:0];
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   // stop offering and let every pending result come back
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_capacity(input int value);
      wait_idle();
      csr_wdata <= value[CAP_W-1:0];
      csr_we    <= 1'b1;
      @(negedge clock);
      csr_we    <= 1'b0;
      @(negedge clock);
      cur_cap = (value == 0) ? 1 : ((value > DEPTH) ? DEPTH : value);
   endtask

   // mostly well-formed operations, some bad lengths and spare codes
   task automatic random_item(input int write_bias);
      logic [OP_W-1:0] code;
      int              pick;
      int              amt;
      int              ofs;
      pick = $urandom_range(0, 99);
      if (pick < write_bias) begin
         code = OP_WRITE;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 50) code = OP_READ;
         else if (pick < 78) code = OP_PEEK;
         else if (pick < 92) code = OP_DRAIN;
         else if (pick < 96) code = OP_CLEAR;
         else code = OP_W'($urandom_range(OP_CODE_SPARE, OP_CODE_TOP));
      end
      pick = $urandom_range(0, 99);
      if (code == OP_DRAIN)
         amt = (pick < 70) ? $urandom_range(0, WORD_BYTES) :
               (pick < 92) ? $urandom_range(0, cur_cap) : $urandom_range(0, AMT_MAX);
      else
         amt = (pick < 94) ? $urandom_range(1, WORD_BYTES) :
               (pick < 97) ? 0 : $urandom_range(WORD_BYTES + 1, AMT_MAX);
      pick = $urandom_range(0, 99);
      if (code == OP_PEEK && pick < 50) ofs = $urandom_range(0, 15);
      else if (code == OP_PEEK && pick < 90) ofs = $urandom_range(0, cur_cap - 1);
      else ofs = $urandom_range(0, OFS_MAX);
      send_item(code, {$urandom, $urandom}, amt, ofs);
   endtask

   // result side: random stalls, plus a long hold-off when asked
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (holds_done < holds_asked) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            holds_done++;
         end
         stall = snk_stalls_on ? $urandom_range(0, 14) : 0;
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         @(negedge clock);
      end
   end

   // run limit
   initial begin
      #10_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // stimulus and verdict
   initial begin
      int bias;
      req_bus.valid     = 1'b0;
      req_bus.operation = OP_WRITE;
      req_bus.data_in   = '0;
      req_bus.amount    = '0;
      req_bus.offset    = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty ring refusals and length checks
      send_item(OP_READ,  '0, 1, 0);
      send_item(OP_PEEK,  '0, 1, 0);
      send_item(OP_DRAIN, '0, 0, 0);
      send_item(OP_DRAIN, '0, AMT_MAX, OFS_MAX);
      send_item(OP_WRITE, '1, 0, 0);
      send_item(OP_WRITE, '1, WORD_BYTES + 1, 0);
      send_item(OP_WRITE, '1, AMT_MAX, 0);
      send_item(OP_READ,  '0, 0, 0);
      send_item(OP_PEEK,  '0, WORD_BYTES + 1, 0);
      // fill a little, then peek around the edge of the stored data
      send_item(OP_WRITE, '1, WORD_BYTES, 0);
      send_item(OP_WRITE, 64'h0123_4567_89ab_cdef, WORD_BYTES, 0);
      send_item(OP_WRITE, '0, 1, 0);
      send_item(OP_PEEK,  '0, WORD_BYTES, 0);
      send_item(OP_PEEK,  '0, WORD_BYTES, 9);
      send_item(OP_PEEK,  '0, WORD_BYTES, 10);
      send_item(OP_PEEK,  '0, 1, OFS_MAX);
      send_item(OP_READ,  '0, 3, 0);
      send_item(OP_DRAIN, '0, 5, 0);
      send_item(OP_READ,  '0, WORD_BYTES, 0);
      send_item(OP_DRAIN, '0, 1, 0);
      send_item(OP_WRITE, '1, 5, 0);
      send_item(OP_CLEAR, '0, 0, 0);
      send_item(OP_CODE_SPARE, '1, AMT_MAX, OFS_MAX);
      send_item(OP_CODE_TOP, '1, 1, 0);

      // zero capacity means a one byte ring
      write_capacity(0);
      send_item(OP_WRITE, 64'hff, 1, 0);
      send_item(OP_WRITE, 64'h5a, 1, 0);
      send_item(OP_PEEK,  '0, 1, 0);
      send_item(OP_READ,  '0, 1, 0);

      // random phases over several ring sizes
      for (int p = 0; p < 10; p++) begin
         src_gaps_on   = !(p % 3 == 1 || p == 8);
         snk_stalls_on = !(p % 3 == 1 || p == 6);
         write_capacity(phase_caps[p]);
         for (int n = 0; n < 110; n++) begin
            bias = ((n / 40) % 2 == 0) ? 65 : 25;
            random_item(bias);
         end
      end

      // fill the full ring while the result side holds off
      write_capacity(DEPTH);
      src_gaps_on   = 1'b0;
      snk_stalls_on = 1'b1;
      holds_asked++;
      for (int n = 0; n < 140; n++)
         send_item(OP_WRITE, {$urandom, $urandom}, WORD_BYTES, $urandom_range(0, OFS_MAX));
      wait_idle();
      src_gaps_on = 1'b1;
      for (int n = 0; n < 20; n++)
         send_item(OP_PEEK, '0, $urandom_range(1, WORD_BYTES),
                   $urandom_range(DEPTH - 2 * WORD_BYTES, OFS_MAX));
      for (int n = 0; n < 130; n++)
         send_item(OP_READ, {$urandom, $urandom}, WORD_BYTES, $urandom_range(0, OFS_MAX));

      // drain what is still in flight
      req_bus.valid <= 1'b0;
      for (int i = 0; i < 5000 && pending_count != 0; i++) @(negedge clock);
      repeat (5) @(negedge clock);
      if (pending_count != 0)
         $display("%0d results never arrived", pending_count);
      if (fail_count == 0 && pending_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
